/* rtl/rod_pkg.sv */
// ----------------------------------------------------------------------------
// rod_pkg
// Shared types and opcode constants for the RISC-V operand decoder.
// ----------------------------------------------------------------------------
package rod_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned HalfW = 16;
  localparam int unsigned RegW  = 5;
  localparam int unsigned ImmW  = 32;
  localparam int unsigned CsrW  = 12;

  // 32-bit major opcodes
  typedef enum logic [6:0] {
    OPC_LUI      = 7'h37,
    OPC_AUIPC    = 7'h17,
    OPC_JAL      = 7'h6f,
    OPC_JALR     = 7'h67,
    OPC_BRANCH   = 7'h63,
    OPC_LOAD     = 7'h03,
    OPC_LOAD_FP  = 7'h07,
    OPC_STORE    = 7'h23,
    OPC_STORE_FP = 7'h27,
    OPC_OP_IMM   = 7'h13,
    OPC_OP_IMM32 = 7'h1b,
    OPC_OP       = 7'h33,
    OPC_OP32     = 7'h3b,
    OPC_AMO      = 7'h2f,
    OPC_FENCE    = 7'h0f,
    OPC_SYSTEM   = 7'h73
  } rod_opc_t;

  // compressed quadrants
  typedef enum logic [1:0] {
    QUAD_0   = 2'b00,
    QUAD_1   = 2'b01,
    QUAD_2   = 2'b10,
    QUAD_32B = 2'b11
  } rod_quad_t;

  localparam logic [RegW-1:0] RegZero = 5'd0;
  localparam logic [RegW-1:0] RegRa   = 5'd1;
  localparam logic [RegW-1:0] RegSp   = 5'd2;

  typedef struct packed {
    logic                   status;
    logic                   compressed;
    logic                   dest_valid;
    logic [RegW-1:0]        dest_reg;
    logic                   src1_valid;
    logic [RegW-1:0]        src1_reg;
    logic                   src2_valid;
    logic [RegW-1:0]        src2_reg;
    logic                   imm_valid;
    logic [ImmW-1:0]        imm_value;
    logic                   csr_valid;
    logic [CsrW-1:0]        csr_number;
  } rod_ops_t;

  localparam rod_ops_t OpsNone = '0;

endpackage

/* rtl/rod_dec16.sv */
// ----------------------------------------------------------------------------
// rod_dec16
// Operand field extraction for 16-bit compressed instructions.
// ----------------------------------------------------------------------------
module rod_dec16 (
  input  logic [rod_pkg::HalfW-1:0] half_word,
  output rod_pkg::rod_ops_t         ops,
  output logic                      ok
);
  import rod_pkg::*;

  logic [15:0]     c;
  logic [2:0]      f3;
  logic [1:0]      quad;
  logic [RegW-1:0] rd;
  logic [RegW-1:0] rs2;
  logic [RegW-1:0] rds;
  logic [RegW-1:0] rs1s;
  logic [31:0]     n6;
  logic [31:0]     u6;
  logic [31:0]     wofs;
  logic [31:0]     dofs;

  assign c    = half_word;
  assign f3   = c[15:13];
  assign quad = c[1:0];
  assign rd   = c[11:7];
  assign rs2  = c[6:2];
  assign rds  = {2'b01, c[4:2]};
  assign rs1s = {2'b01, c[9:7]};
  assign n6   = {{26{c[12]}}, c[12], c[6:2]};
  assign u6   = {26'd0, c[12], c[6:2]};
  assign wofs = {25'd0, c[5], c[12:10], c[6], 2'b00};
  assign dofs = {24'd0, c[6:5], c[12:10], 3'b000};

  always_comb begin
    ops = OpsNone;
    ok  = 1'b1;
    ops.compressed = 1'b1;
    unique case (quad)
      QUAD_0: begin
        unique case (f3)
          3'd0: begin
            ops.dest_valid = 1'b1; ops.dest_reg = rds;
            ops.src1_valid = 1'b1; ops.src1_reg = RegSp;
            ops.imm_valid  = 1'b1;
            ops.imm_value  = {22'd0, c[10:7], c[12:11], c[5], c[6], 2'b00};
          end
          3'd1, 3'd2, 3'd3: begin
            ops.dest_valid = 1'b1; ops.dest_reg = rds;
            ops.src1_valid = 1'b1; ops.src1_reg = rs1s;
            ops.imm_valid  = 1'b1;
            ops.imm_value  = (f3 == 3'd2) ? wofs : dofs;
          end
          3'd4: begin
            ok = 1'b0;
          end
          default: begin
            ops.src2_valid = 1'b1; ops.src2_reg = rds;
            ops.src1_valid = 1'b1; ops.src1_reg = rs1s;
            ops.imm_valid  = 1'b1;
            ops.imm_value  = (f3 == 3'd6) ? wofs : dofs;
          end
        endcase
      end
      QUAD_1: begin
        unique case (f3)
          3'd0, 3'd1: begin
            ops.dest_valid = 1'b1; ops.dest_reg = rd;
            ops.src1_valid = 1'b1; ops.src1_reg = rd;
            ops.imm_valid  = 1'b1; ops.imm_value = n6;
          end
          3'd2: begin
            ops.dest_valid = 1'b1; ops.dest_reg = rd;
            ops.src1_valid = 1'b1; ops.src1_reg = RegZero;
            ops.imm_valid  = 1'b1; ops.imm_value = n6;
          end
          3'd3: begin
            ops.dest_valid = 1'b1;
            ops.imm_valid  = 1'b1;
            if (rd == RegSp) begin
              ops.dest_reg   = RegSp;
              ops.src1_valid = 1'b1; ops.src1_reg = RegSp;
              ops.imm_value  = {{23{c[12]}}, c[4:3], c[5], c[2], c[6], 4'd0};
            end else begin
              ops.dest_reg  = rd;
              ops.imm_value = {{15{c[12]}}, c[6:2], 12'd0};
            end
          end
          3'd4: begin
            ops.dest_valid = 1'b1; ops.dest_reg = rs1s;
            ops.src1_valid = 1'b1; ops.src1_reg = rs1s;
            unique case (c[11:10])
              2'd0, 2'd1: begin
                ops.imm_valid = 1'b1; ops.imm_value = u6;
              end
              2'd2: begin
                ops.imm_valid = 1'b1; ops.imm_value = n6;
              end
              default: begin
                ops.src2_valid = 1'b1; ops.src2_reg = rds;
              end
            endcase
          end
          3'd5: begin
            ops.imm_valid = 1'b1;
            ops.imm_value = {{21{c[12]}}, c[8], c[10:9], c[6], c[7], c[2], c[11],
                             c[5:3], 1'b0};
          end
          default: begin
            ops.src1_valid = 1'b1; ops.src1_reg = rs1s;
            ops.src2_valid = 1'b1; ops.src2_reg = RegZero;
            ops.imm_valid  = 1'b1;
            ops.imm_value  = {{24{c[12]}}, c[6:5], c[2], c[11:10], c[4:3], 1'b0};
          end
        endcase
      end
      QUAD_2: begin
        unique case (f3)
          3'd0: begin
            ops.dest_valid = 1'b1; ops.dest_reg = rd;
            ops.src1_valid = 1'b1; ops.src1_reg = rd;
            ops.imm_valid  = 1'b1; ops.imm_value = u6;
          end
          3'd1, 3'd2, 3'd3: begin
            ops.dest_valid = 1'b1; ops.dest_reg = rd;
            ops.src1_valid = 1'b1; ops.src1_reg = RegSp;
            ops.imm_valid  = 1'b1;
            if (f3 == 3'd2) begin
              ops.imm_value = {24'd0, c[3:2], c[12], c[6:4], 2'b00};
            end else begin
              ops.imm_value = {23'd0, c[4:2], c[12], c[6:5], 3'b000};
            end
          end
          3'd4: begin
            priority if (!c[12] && rs2 == RegZero) begin
              ops.src1_valid = 1'b1; ops.src1_reg = rd;
            end else if (!c[12]) begin
              ops.dest_valid = 1'b1; ops.dest_reg = rd;
              ops.src1_valid = 1'b1; ops.src1_reg = RegZero;
              ops.src2_valid = 1'b1; ops.src2_reg = rs2;
            end else if (rd == RegZero && rs2 == RegZero) begin
              ops.status = 1'b0;
            end else if (rs2 == RegZero) begin
              ops.dest_valid = 1'b1; ops.dest_reg = RegRa;
              ops.src1_valid = 1'b1; ops.src1_reg = rd;
            end else begin
              ops.dest_valid = 1'b1; ops.dest_reg = rd;
              ops.src1_valid = 1'b1; ops.src1_reg = rd;
              ops.src2_valid = 1'b1; ops.src2_reg = rs2;
            end
          end
          default: begin
            ops.src2_valid = 1'b1; ops.src2_reg = rs2;
            ops.src1_valid = 1'b1; ops.src1_reg = RegSp;
            ops.imm_valid  = 1'b1;
            if (f3 == 3'd6) begin
              ops.imm_value = {24'd0, c[8:7], c[12:9], 2'b00};
            end else begin
              ops.imm_value = {23'd0, c[9:7], c[12:10], 3'b000};
            end
          end
        endcase
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/rod_dec32.sv */
// ----------------------------------------------------------------------------
// rod_dec32
// Operand field extraction for 32-bit instructions.
// ----------------------------------------------------------------------------
module rod_dec32 (
  input  logic [rod_pkg::WordW-1:0] word,
  output rod_pkg::rod_ops_t         ops,
  output logic                      ok
);
  import rod_pkg::*;

  logic [6:0]      opc;
  logic [2:0]      f3;
  logic [RegW-1:0] rd;
  logic [RegW-1:0] rs1;
  logic [RegW-1:0] rs2;
  logic [31:0]     iimm;
  logic [31:0]     simm;
  logic [31:0]     bimm;
  logic [31:0]     uimm;
  logic [31:0]     jimm;

  assign opc  = word[6:0];
  assign f3   = word[14:12];
  assign rd   = word[11:7];
  assign rs1  = word[19:15];
  assign rs2  = word[24:20];
  assign iimm = {{20{word[31]}}, word[31:20]};
  assign simm = {{20{word[31]}}, word[31:25], word[11:7]};
  assign bimm = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
  assign uimm = {word[31:12], 12'd0};
  assign jimm = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};

  always_comb begin
    ops = OpsNone;
    ok  = 1'b1;
    unique case (opc)
      OPC_LUI, OPC_AUIPC: begin
        ops.dest_valid = 1'b1; ops.dest_reg = rd;
        ops.imm_valid  = 1'b1; ops.imm_value = uimm;
      end
      OPC_JAL: begin
        ops.dest_valid = 1'b1; ops.dest_reg = rd;
        ops.imm_valid  = 1'b1; ops.imm_value = jimm;
      end
      OPC_JALR, OPC_LOAD, OPC_LOAD_FP: begin
        ops.dest_valid = 1'b1; ops.dest_reg = rd;
        ops.src1_valid = 1'b1; ops.src1_reg = rs1;
        ops.imm_valid  = 1'b1; ops.imm_value = iimm;
      end
      OPC_BRANCH: begin
        ops.src1_valid = 1'b1; ops.src1_reg = rs1;
        ops.src2_valid = 1'b1; ops.src2_reg = rs2;
        ops.imm_valid  = 1'b1; ops.imm_value = bimm;
      end
      OPC_STORE, OPC_STORE_FP: begin
        ops.src1_valid = 1'b1; ops.src1_reg = rs1;
        ops.src2_valid = 1'b1; ops.src2_reg = rs2;
        ops.imm_valid  = 1'b1; ops.imm_value = simm;
      end
      OPC_OP_IMM, OPC_OP_IMM32: begin
        ops.dest_valid = 1'b1; ops.dest_reg = rd;
        ops.src1_valid = 1'b1; ops.src1_reg = rs1;
        ops.imm_valid  = 1'b1;
        ops.imm_value  = (f3 == 3'd1 || f3 == 3'd5) ? {26'd0, word[25:20]} : iimm;
      end
      OPC_OP, OPC_OP32, OPC_AMO: begin
        ops.dest_valid = 1'b1; ops.dest_reg = rd;
        ops.src1_valid = 1'b1; ops.src1_reg = rs1;
        ops.src2_valid = 1'b1; ops.src2_reg = rs2;
      end
      OPC_FENCE: begin
        ops.imm_valid = 1'b1; ops.imm_value = iimm;
      end
      OPC_SYSTEM: begin
        if (f3 != 3'd0) begin
          ops.dest_valid = 1'b1; ops.dest_reg = rd;
          ops.csr_valid  = 1'b1; ops.csr_number = word[31:20];
          ops.imm_valid  = 1'b1;
          if (f3 >= 3'd5) begin
            ops.imm_value = {27'd0, rs1};
          end else begin
            ops.src1_valid = 1'b1; ops.src1_reg = rs1;
            ops.imm_value  = {20'd0, word[31:20]};
          end
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/riscv_operand_decoder.sv */
// ----------------------------------------------------------------------------
// riscv_operand_decoder
// Operand field decoder for RV64GC instruction words, one request per cycle unless stalled.
//
//   channel  | valid      | stall      | payload
//   ---------+------------+------------+-------------------------------------
//   request  | in_valid   | in_stall   | instr_word
//   result   | out_valid  | out_stall  | status .. csr_number
//
// one request per cycle sustained while out_stall is low
// each request passes the request register, the decode and then the result register
// reset clears both valid flags; payload registers are not reset
// in_stall rises only when the request register is full and the result is held
// ----------------------------------------------------------------------------
module riscv_operand_decoder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [rod_pkg::WordW-1:0]  instr_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       status,
  output logic                       is_compressed,
  output logic                       dest_valid,
  output logic [rod_pkg::RegW-1:0]   dest_reg,
  output logic                       src1_valid,
  output logic [rod_pkg::RegW-1:0]   src1_reg,
  output logic                       src2_valid,
  output logic [rod_pkg::RegW-1:0]   src2_reg,
  output logic                       imm_valid,
  output logic signed [rod_pkg::ImmW-1:0] imm_value,
  output logic                       csr_valid,
  output logic [rod_pkg::CsrW-1:0]   csr_number
);
  import rod_pkg::*;

  logic             req_valid;
  logic [WordW-1:0] req_word;
  rod_ops_t         res;
  rod_ops_t         res_next;
  rod_ops_t         ops16;
  rod_ops_t         ops32;
  logic             ok16;
  logic             ok32;
  logic             is16;
  logic             out_free;
  logic             out_load;
  logic             req_ready;

  rod_dec16 u_dec16 (
    .half_word (req_word[HalfW-1:0]),
    .ops       (ops16),
    .ok        (ok16)
  );

  rod_dec32 u_dec32 (
    .word (req_word),
    .ops  (ops32),
    .ok   (ok32)
  );

  assign is16 = (req_word[1:0] != QUAD_32B);

  always_comb begin
    res_next = OpsNone;
    if (is16 ? ok16 : ok32) begin
      res_next = is16 ? ops16 : ops32;
    end else begin
      res_next.status = 1'b1;
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign out_load  = req_valid && out_free;
  assign req_ready = !req_valid || out_load;
  assign in_stall  = !req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_ready) begin
      req_valid <= in_valid;
    end
    if (in_valid && req_ready) begin
      req_word <= instr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= req_valid;
    end
    if (out_load) begin
      res <= res_next;
    end
  end

  assign status        = res.status;
  assign is_compressed = res.compressed;
  assign dest_valid    = res.dest_valid;
  assign dest_reg      = res.dest_reg;
  assign src1_valid    = res.src1_valid;
  assign src1_reg      = res.src1_reg;
  assign src2_valid    = res.src2_valid;
  assign src2_reg      = res.src2_reg;
  assign imm_valid     = res.imm_valid;
  assign imm_value     = $signed(res.imm_value);
  assign csr_valid     = res.csr_valid;
  assign csr_number    = res.csr_number;

  a_status_clean : assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !is_compressed && !dest_valid && !src1_valid &&
      !src2_valid && !imm_valid && !csr_valid)
    else $error("unrecognized result carries fields");

  a_csr_form : assert property (@(posedge clk) disable iff (rst)
    out_valid && csr_valid |-> imm_valid && dest_valid && !is_compressed)
    else $error("csr result without immediate or destination");

  a_req_hold : assert property (@(posedge clk) disable iff (rst)
    req_valid && !out_free |=> req_valid && $stable(req_word))
    else $error("held request lost or changed");

  a_no_drop : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res))
    else $error("stalled result changed");

  a_absent_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !dest_valid |-> dest_reg == RegZero)
    else $error("absent destination not zero");

endmodule
